// ===== sv/cnms_pkg.sv =====
// Shared types, constants and the angle binning function for the Canny
// non-maximum suppression block. No dependencies.
`timescale 1ns / 1ps

package cnms_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAG_BITS  = 16;

    // Frame geometry.
    localparam int MAX_HEIGHT   = 4096;
    localparam int ROW_BITS     = 12;
    localparam int HEIGHT_BITS  = 13;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Configuration port.
    localparam int CFG_WIDTH_BITS = 11;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Stream payload.
    localparam int FIELD_BITS      = 16;
    localparam int IN_DATA_BITS    = 2 * FIELD_BITS;
    localparam int OUT_DATA_BITS   = FIELD_BITS;
    localparam int ANGLE_FRAC_BITS = 15;

    // Ring of row stores.
    localparam int SLOT_COUNT = 4;
    localparam int SLOT_BITS  = 2;
    typedef logic [SLOT_BITS-1:0] slot_t;

    // Direction bins and their edges (32768 units = pi).
    localparam int BIN_BITS = 2;
    typedef enum logic [BIN_BITS-1:0] {
        BIN_HORZ,
        BIN_DIAG_NW,
        BIN_VERT,
        BIN_DIAG_NE
    } bin_t;

    localparam logic [ANGLE_FRAC_BITS-1:0] ANGLE_22_5  = 15'd4096;
    localparam logic [ANGLE_FRAC_BITS-1:0] ANGLE_67_5  = 15'd12288;
    localparam logic [ANGLE_FRAC_BITS-1:0] ANGLE_112_5 = 15'd20480;
    localparam logic [ANGLE_FRAC_BITS-1:0] ANGLE_157_5 = 15'd28672;

    // Window indexes.
    localparam int WIN_COLS = 3;
    localparam int WIN_ROWS = 3;
    localparam int COL_L    = 0;
    localparam int COL_C    = 1;
    localparam int COL_R    = 2;
    localparam int ROW_UP   = 0;
    localparam int ROW_MID  = 1;
    localparam int ROW_DN   = 2;

    // Control that travels with one result from the sequencer to the window.
    typedef struct packed {
        slot_t mid_slot;
        logic  up_clamp;
        logic  dn_clamp;
        logic  first_col;
        logic  end_of_row;
        logic  end_of_frame;
    } emit_ctrl_t;

    // Folding a negative angle by adding pi keeps just the low 15 bits.
    function automatic bin_t angle_bin(input logic [ANGLE_FRAC_BITS-1:0] u);
        bin_t b;
        if ((u < ANGLE_22_5) || (u >= ANGLE_157_5)) begin
            b = BIN_HORZ;
        end else if (u < ANGLE_67_5) begin
            b = BIN_DIAG_NW;
        end else if (u < ANGLE_112_5) begin
            b = BIN_VERT;
        end else begin
            b = BIN_DIAG_NE;
        end
        return b;
    endfunction

endpackage

// ===== sv/cnms_line_mem.sv =====
// One row store of the ring: one write port, two registered read ports.
// Depends on nothing; a write to a read address in the same cycle is forwarded.
`timescale 1ns / 1ps

module cnms_line_mem #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 18
)(
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [DATA_BITS-1:0]         wdata,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     raddr_a,
    input  logic [$clog2(DEPTH)-1:0]     raddr_b,
    output logic [DATA_BITS-1:0]         rdata_a,
    output logic [DATA_BITS-1:0]         rdata_b
);

    logic [DATA_BITS-1:0] mem_reg [DEPTH];
    logic [DATA_BITS-1:0] rdata_a_reg;
    logic [DATA_BITS-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= (we && (waddr == raddr_a)) ? wdata : mem_reg[raddr_a];
            rdata_b_reg <= (we && (waddr == raddr_b)) ? wdata : mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== sv/cnms_seq.sv =====
// Position sequencer: configuration registers, input and output raster
// positions, ring slots and the pending count. Depends on cnms_pkg.
`timescale 1ns / 1ps

module cnms_seq
    import cnms_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]         cfg_index,
    input  logic [CFG_DATA_BITS-1:0]          cfg_data,
    input  logic                              beat,
    input  logic                              is_flush,
    output logic                              emit,
    output logic                              wr_en,
    output slot_t                             wr_slot,
    output logic [$clog2(MAX_WIDTH)-1:0]      wr_col,
    output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr_a,
    output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr_b,
    output emit_ctrl_t                        ctrl
);

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int WID_BITS  = $clog2(MAX_WIDTH + 1);
    localparam int PEND_BITS = $clog2(MAX_WIDTH + 2);
    localparam int REQ_BITS  = (WID_BITS > CFG_WIDTH_BITS) ? WID_BITS : CFG_WIDTH_BITS;
    localparam int RESET_W   = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

    logic [WID_BITS-1:0]    width_reg, width_next;
    logic [HEIGHT_BITS-1:0] height_reg, height_next;
    logic [COL_BITS-1:0]    in_col_reg, in_col_next;
    logic [COL_BITS-1:0]    out_col_reg, out_col_next;
    logic [ROW_BITS-1:0]    in_row_reg, in_row_next;
    logic [ROW_BITS-1:0]    out_row_reg, out_row_next;
    slot_t                  in_slot_reg, in_slot_next;
    slot_t                  out_slot_reg, out_slot_next;
    logic [PEND_BITS-1:0]   pending_reg, pending_next;

    logic [REQ_BITS-1:0]    width_req;
    logic [HEIGHT_BITS-1:0] height_req;
    logic                   in_col_last;
    logic                   in_row_last;
    logic                   out_col_last;
    logic                   out_row_last;
    logic                   at_frame_start;
    logic                   pending_full;

    assign width_req  = REQ_BITS'(cfg_data[CFG_WIDTH_BITS-1:0]);
    assign height_req = cfg_data[HEIGHT_BITS-1:0];

    assign in_col_last  = (WID_BITS'(in_col_reg) + WID_BITS'(1)) == width_reg;
    assign out_col_last = (WID_BITS'(out_col_reg) + WID_BITS'(1)) == width_reg;
    assign in_row_last  = (HEIGHT_BITS'(in_row_reg) + HEIGHT_BITS'(1)) == height_reg;
    assign out_row_last = (HEIGHT_BITS'(out_row_reg) + HEIGHT_BITS'(1)) == height_reg;

    assign at_frame_start = (in_col_reg == '0) && (in_row_reg == '0);
    assign pending_full   = pending_reg == (PEND_BITS'(width_reg) + PEND_BITS'(1));

    // A flush only drains once the input has wrapped to the start of a frame.
    assign emit = is_flush ? (at_frame_start && (pending_reg != '0)) : pending_full;

    assign wr_en   = beat && !is_flush;
    assign wr_slot = in_slot_reg;
    assign wr_col  = in_col_reg;

    // Port A fetches the center column at the start of a row, port B the
    // column to the right, clamped at the right edge.
    assign rd_addr_a = out_col_reg;
    assign rd_addr_b = out_col_last ? out_col_reg : out_col_reg + COL_BITS'(1);

    assign ctrl.mid_slot     = out_slot_reg;
    assign ctrl.up_clamp     = (out_row_reg == '0);
    assign ctrl.dn_clamp     = out_row_last;
    assign ctrl.first_col    = (out_col_reg == '0);
    assign ctrl.end_of_row   = out_col_last;
    assign ctrl.end_of_frame = out_col_last && out_row_last;

    always_comb
    begin
        width_next    = width_reg;
        height_next   = height_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        pending_next  = pending_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    if (width_req == '0)
                    begin
                        width_next = WID_BITS'(1);
                    end
                    else if (width_req > REQ_BITS'(MAX_WIDTH))
                    begin
                        width_next = WID_BITS'(MAX_WIDTH);
                    end
                    else
                    begin
                        width_next = WID_BITS'(width_req);
                    end
                end
                CFG_IMAGE_HEIGHT:
                begin
                    if (height_req == '0)
                    begin
                        height_next = HEIGHT_BITS'(1);
                    end
                    else if (height_req > HEIGHT_BITS'(MAX_HEIGHT))
                    begin
                        height_next = HEIGHT_BITS'(MAX_HEIGHT);
                    end
                    else
                    begin
                        height_next = height_req;
                    end
                end
                default:
                begin
                end
            endcase
            // Any write restarts the stream; stored rows are kept.
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
            pending_next  = '0;
        end
        else if (beat)
        begin
            if (!is_flush)
            begin
                if (in_col_last)
                begin
                    in_col_next  = '0;
                    in_slot_next = in_slot_reg + slot_t'(1);
                    in_row_next  = in_row_last ? '0 : in_row_reg + ROW_BITS'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_BITS'(1);
                end
                if (!pending_full)
                begin
                    pending_next = pending_reg + PEND_BITS'(1);
                end
            end
            else if (emit)
            begin
                pending_next = pending_reg - PEND_BITS'(1);
            end

            if (emit)
            begin
                if (out_col_last)
                begin
                    out_col_next  = '0;
                    out_slot_next = out_slot_reg + slot_t'(1);
                    out_row_next  = out_row_last ? '0 : out_row_reg + ROW_BITS'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WID_BITS'(RESET_W);
            height_reg   <= HEIGHT_BITS'(RESET_HEIGHT);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            pending_reg  <= '0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
            pending_reg  <= pending_next;
        end
    end

endmodule

// ===== sv/cnms_window.sv =====
// 3x3 magnitude window fed from the row store reads, and the peak test along
// the center pixel's direction bin. Depends on cnms_pkg.
`timescale 1ns / 1ps

module cnms_window
    import cnms_pkg::*;
#(
    parameter int MAG_W = DEF_MAG_BITS
)(
    input  logic                        clk,
    input  logic                        load,
    input  emit_ctrl_t                  ctrl,
    input  logic [MAG_W+BIN_BITS-1:0]   rd_a [SLOT_COUNT],
    input  logic [MAG_W+BIN_BITS-1:0]   rd_b [SLOT_COUNT],
    output logic [MAG_W-1:0]            thin_mag
);

    localparam int WORD_BITS = MAG_W + BIN_BITS;

    slot_t                 up_slot;
    slot_t                 dn_slot;
    logic [WORD_BITS-1:0]  a_mid;
    logic [WORD_BITS-1:0]  b_mid;
    logic [MAG_W-1:0]      a_col [WIN_ROWS];
    logic [MAG_W-1:0]      b_col [WIN_ROWS];
    logic [MAG_W-1:0]      win_reg  [WIN_COLS][WIN_ROWS];
    logic [MAG_W-1:0]      win_next [WIN_COLS][WIN_ROWS];
    bin_t                  center_bin_next;
    bin_t                  right_bin_reg, right_bin_next;
    logic [MAG_W-1:0]      m;
    logic [MAG_W-1:0]      m1;
    logic [MAG_W-1:0]      m2;

    assign up_slot = ctrl.mid_slot - slot_t'(1);
    assign dn_slot = ctrl.mid_slot + slot_t'(1);
    assign a_mid   = rd_a[ctrl.mid_slot];
    assign b_mid   = rd_b[ctrl.mid_slot];

    // Rows outside the frame are replaced by the center row.
    always_comb
    begin
        a_col[ROW_MID] = a_mid[MAG_W-1:0];
        b_col[ROW_MID] = b_mid[MAG_W-1:0];
        a_col[ROW_UP]  = ctrl.up_clamp ? a_mid[MAG_W-1:0] : rd_a[up_slot][MAG_W-1:0];
        b_col[ROW_UP]  = ctrl.up_clamp ? b_mid[MAG_W-1:0] : rd_b[up_slot][MAG_W-1:0];
        a_col[ROW_DN]  = ctrl.dn_clamp ? a_mid[MAG_W-1:0] : rd_a[dn_slot][MAG_W-1:0];
        b_col[ROW_DN]  = ctrl.dn_clamp ? b_mid[MAG_W-1:0] : rd_b[dn_slot][MAG_W-1:0];
    end

    // At the first column the left neighbor is the center itself.
    always_comb
    begin
        for (int r = 0; r < WIN_ROWS; r++)
        begin
            win_next[COL_L][r] = ctrl.first_col ? a_col[r] : win_reg[COL_C][r];
            win_next[COL_C][r] = ctrl.first_col ? a_col[r] : win_reg[COL_R][r];
            win_next[COL_R][r] = b_col[r];
        end
        center_bin_next = ctrl.first_col ? bin_t'(a_mid[WORD_BITS-1:MAG_W]) : right_bin_reg;
        right_bin_next  = bin_t'(b_mid[WORD_BITS-1:MAG_W]);
    end

    always_comb
    begin
        m  = win_next[COL_C][ROW_MID];
        m1 = win_next[COL_L][ROW_MID];
        m2 = win_next[COL_R][ROW_MID];
        case (center_bin_next)
            BIN_HORZ:
            begin
                m1 = win_next[COL_L][ROW_MID];
                m2 = win_next[COL_R][ROW_MID];
            end
            BIN_DIAG_NW:
            begin
                m1 = win_next[COL_L][ROW_UP];
                m2 = win_next[COL_R][ROW_DN];
            end
            BIN_VERT:
            begin
                m1 = win_next[COL_C][ROW_UP];
                m2 = win_next[COL_C][ROW_DN];
            end
            BIN_DIAG_NE:
            begin
                m1 = win_next[COL_R][ROW_UP];
                m2 = win_next[COL_L][ROW_DN];
            end
        endcase
        thin_mag = ((m >= m1) && (m > m2)) ? m : '0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            win_reg       <= win_next;
            right_bin_reg <= right_bin_next;
        end
    end

endmodule

// ===== sv/canny_nonmax_suppression.sv =====
// Top level of the Canny non-maximum suppression block: stream ports, the
// ring of row stores and the result register. Depends on cnms_pkg, cnms_seq,
// cnms_line_mem and cnms_window.
`timescale 1ns / 1ps

// Four-direction Canny non-maximum suppression on a raster stream. Each input
// beat is either a pixel (s_tuser low) carrying a gradient magnitude and a
// gradient angle, or a flush tick (s_tuser high). A pixel's angle, folded into
// [0, pi), selects one of four direction bins; the result is the magnitude if
// it is at least the first neighbor along that direction and strictly greater
// than the second, otherwise zero, with neighbors past the frame border
// clamped to the edge. Results come out in raster order one row and one pixel
// (width + 1 pixel beats) behind the input, so after the last pixel of a frame
// the remaining width + 1 results are drained by flush ticks; a flush tick
// given mid-frame or with nothing pending is dropped without a result. The
// block takes one beat every clock unless stalled: the row stores capture their
// reads at the edge that accepts the beat, and the window update and peak
// compare then load the output register from those reads. The only stall is
// back-pressure from m_tready, which holds the single read stage and the
// output register. Writing either configuration register restarts the stream
// (positions and pending count are cleared); write only while idle.
// There is no clearing pass after reset.
module canny_nonmax_suppression
    import cnms_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAG_BITS  = DEF_MAG_BITS
)(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [IN_DATA_BITS-1:0]     s_tdata,   // [15:0] magnitude, [31:16] angle
    input  logic                        s_tuser,   // [0] command

    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [OUT_DATA_BITS-1:0]    m_tdata,   // [15:0] thin_magnitude
    output logic                        m_tlast,   // end_of_row
    output logic                        m_tuser    // [0] end_of_frame
);

    // Stored magnitudes are at most one field wide.
    localparam int MAG_W     = (MAG_BITS < FIELD_BITS) ? MAG_BITS : FIELD_BITS;
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int WORD_BITS = MAG_W + BIN_BITS;

    logic                  beat;
    logic                  emit;
    logic                  wr_en;
    slot_t                 wr_slot;
    logic [COL_BITS-1:0]   wr_col;
    logic [COL_BITS-1:0]   rd_addr_a;
    logic [COL_BITS-1:0]   rd_addr_b;
    logic                  rd_en;
    emit_ctrl_t            beat_ctrl;
    bin_t                  wr_bin;
    logic [WORD_BITS-1:0]  wr_data;
    logic [WORD_BITS-1:0]  rd_a [SLOT_COUNT];
    logic [WORD_BITS-1:0]  rd_b [SLOT_COUNT];
    logic [MAG_W-1:0]      thin_mag;

    logic                  out_free;
    logic                  p1_adv;
    logic                  p1_valid_reg, p1_valid_next;
    emit_ctrl_t            p1_ctrl_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [MAG_W-1:0]      out_mag_reg;
    logic                  out_eor_reg;
    logic                  out_eof_reg;

    // The read stage moves on whenever the output register is empty or is
    // being emptied; a new beat may enter whenever the read stage is empty or can move.
    assign out_free = !out_valid_reg || m_tready;
    assign p1_adv   = p1_valid_reg && out_free;
    assign s_tready = !p1_valid_reg || out_free;
    assign beat     = s_tvalid && s_tready;
    assign rd_en    = beat && emit;

    assign wr_bin  = angle_bin(s_tdata[FIELD_BITS+ANGLE_FRAC_BITS-1:FIELD_BITS]);
    assign wr_data = {wr_bin, s_tdata[MAG_W-1:0]};

    cnms_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .beat      (beat),
        .is_flush  (s_tuser),
        .emit      (emit),
        .wr_en     (wr_en),
        .wr_slot   (wr_slot),
        .wr_col    (wr_col),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .ctrl      (beat_ctrl)
    );

    // Four row stores in a ring: the rows above, at and below the output row
    // are read while the input fills the next slot ahead.
    for (genvar g = 0; g < SLOT_COUNT; g++)
    begin : g_slot
        cnms_line_mem #(
            .DEPTH     (MAX_WIDTH),
            .DATA_BITS (WORD_BITS)
        ) u_mem (
            .clk     (clk),
            .we      (wr_en && (wr_slot == slot_t'(g))),
            .waddr   (wr_col),
            .wdata   (wr_data),
            .re      (rd_en),
            .raddr_a (rd_addr_a),
            .raddr_b (rd_addr_b),
            .rdata_a (rd_a[g]),
            .rdata_b (rd_b[g])
        );
    end

    cnms_window #(
        .MAG_W (MAG_W)
    ) u_window (
        .clk      (clk),
        .load     (p1_adv),
        .ctrl     (p1_ctrl_reg),
        .rd_a     (rd_a),
        .rd_b     (rd_b),
        .thin_mag (thin_mag)
    );

    always_comb
    begin
        p1_valid_next = p1_valid_reg;
        if (rd_en)
        begin
            p1_valid_next = 1'b1;
        end
        else if (p1_adv)
        begin
            p1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (p1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            p1_ctrl_reg <= beat_ctrl;
        end
        if (p1_adv)
        begin
            out_mag_reg <= thin_mag;
            out_eor_reg <= p1_ctrl_reg.end_of_row;
            out_eof_reg <= p1_ctrl_reg.end_of_frame;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_BITS'(out_mag_reg);
    assign m_tlast  = out_eor_reg;
    assign m_tuser  = out_eof_reg;

endmodule
